>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the chord generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset
`define CHQB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define CHQB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/chqb_pkg.sv
// ----------------------------------------------------------------------------
// chqb_pkg
// Shared types, codes and the truncating midpoint used by the chord generator.
// ----------------------------------------------------------------------------
package chqb_pkg;

  // Widest coordinate the midpoint helper handles (port widths stay below it)
  localparam int CW_MAX = 32;

  // Points taken so far in the current polyline
  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_MORE = 2'd2;

  // Per-segment control carried from the front end to the chord output
  typedef struct packed {
    logic line;  // straight chord, not subdivided
    logic last;  // rightmost chord of this input point
    logic done;  // rightmost chord of the polyline
  } seg_flags_t;

  localparam int FLAG_BITS = $bits(seg_flags_t);

  // (a + b) / 2 rounded toward zero
  function automatic logic signed [CW_MAX-1:0] half_sum(
    input logic signed [CW_MAX-1:0] a,
    input logic signed [CW_MAX-1:0] b
  );
    logic signed [CW_MAX:0] s;
    s = {a[CW_MAX-1], a} + {b[CW_MAX-1], b};
    s = s + {{CW_MAX{1'b0}}, s[CW_MAX]};
    return s[CW_MAX:1];
  endfunction

endpackage

>>> rtl/chqb_queue.sv
// ----------------------------------------------------------------------------
// chqb_queue
// Small register FIFO; decouples the front end from the subdivider and
// buffers finished chords toward the result port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chqb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `CHQB_ASSERT(a_cnt_bound, (cnt <= CW'(DEPTH)), "queue count overran its depth")
  `CHQB_ASSERT(a_no_overflow, (push |-> !full), "push while queue full")

endmodule

>>> rtl/chqb_front.sv
// ----------------------------------------------------------------------------
// chqb_front
// Point intake: tracks previous point, anchor and point count, and turns
// each point into zero or one segment descriptor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chqb_front #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic signed [W-1:0]        pos_x,
  input  logic signed [W-1:0]        pos_y,
  input  logic                       final_point,
  output logic                       full,
  output logic                       seg_push,
  output logic [2:0][1:0][W-1:0]     seg_pts,
  output chqb_pkg::seg_flags_t       seg_flags,
  input  logic                       seg_full
);
  import chqb_pkg::*;

  logic signed [W-1:0] prev_x;
  logic signed [W-1:0] prev_y;
  logic signed [W-1:0] anchor_x;
  logic signed [W-1:0] anchor_y;
  logic [1:0]          points_seen;
  logic [1:0]          points_seen_next;
  logic                accept;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  function automatic logic signed [W-1:0] hs(
    input logic signed [W-1:0] a,
    input logic signed [W-1:0] b
  );
    logic signed [CW_MAX-1:0] r;
    r = half_sum({{(CW_MAX - W){a[W-1]}}, a}, {{(CW_MAX - W){b[W-1]}}, b});
    return r[W-1:0];
  endfunction

  // a beat is taken only when the segment queue has room
  assign full   = seg_full;
  assign accept = push && !seg_full;

  // end of the segment: final point, or midpoint of the next edge
  assign end_x = final_point ? pos_x : hs(prev_x, pos_x);
  assign end_y = final_point ? pos_y : hs(prev_y, pos_y);

  // segment descriptor
  always_comb begin
    seg_pts[0][0]  = anchor_x;
    seg_pts[0][1]  = anchor_y;
    seg_pts[1][0]  = prev_x;
    seg_pts[1][1]  = prev_y;
    seg_pts[2][0]  = end_x;
    seg_pts[2][1]  = end_y;
    seg_flags.line = 1'b0;
    seg_flags.last = 1'b1;
    seg_flags.done = final_point;
    seg_push       = 1'b0;
    unique case (points_seen)
      PS_NONE: begin
        seg_push = 1'b0;
      end
      PS_ONE: begin
        seg_flags.line = 1'b1;
        seg_pts[2][0]  = pos_x;
        seg_pts[2][1]  = pos_y;
        seg_push       = accept && final_point;
      end
      PS_MORE: begin
        seg_push = accept;
      end
      default: begin
        seg_push = 1'b0;
      end
    endcase
  end

  // point count, saturating, cleared by a final point
  always_comb begin
    if (final_point) begin
      points_seen_next = PS_NONE;
    end else if (points_seen == PS_NONE) begin
      points_seen_next = PS_ONE;
    end else begin
      points_seen_next = PS_MORE;
    end
  end

  // polyline state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      anchor_x    <= '0;
      anchor_y    <= '0;
      points_seen <= PS_NONE;
    end else if (accept) begin
      prev_x      <= pos_x;
      prev_y      <= pos_y;
      points_seen <= points_seen_next;
      if (points_seen == PS_NONE) begin
        anchor_x <= pos_x;
        anchor_y <= pos_y;
      end else if (points_seen == PS_MORE) begin
        anchor_x <= end_x;
        anchor_y <= end_y;
      end
    end
  end

  `CHQB_ASSERT(a_ps_range, (points_seen != 2'd3), "point count left its range")
  `CHQB_ASSERT(a_final_clears,
    ((accept && final_point) |=> (points_seen == PS_NONE)),
    "final point did not restart the polyline")

endmodule

>>> rtl/chqb_split.sv
// ----------------------------------------------------------------------------
// chqb_split
// One subdivision level: holds a quadratic segment and hands out its left
// half, then its right half. Straight chords pass in a single beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chqb_split #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0][1:0][W-1:0] in_pts,
  input  chqb_pkg::seg_flags_t   in_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0][1:0][W-1:0] out_pts,
  output chqb_pkg::seg_flags_t   out_flags
);
  import chqb_pkg::*;

  logic                   valid;
  logic                   phase;
  logic [2:0][1:0][W-1:0] pts;
  seg_flags_t             flags;
  logic [1:0][W-1:0]      pa;
  logic [1:0][W-1:0]      pb;
  logic [1:0][W-1:0]      pm;
  logic                   final_beat;

  function automatic logic signed [W-1:0] hs(
    input logic signed [W-1:0] a,
    input logic signed [W-1:0] b
  );
    logic signed [CW_MAX-1:0] r;
    r = half_sum({{(CW_MAX - W){a[W-1]}}, a}, {{(CW_MAX - W){b[W-1]}}, b});
    return r[W-1:0];
  endfunction

  // midpoints per axis: start/control, control/end, then between those
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pa[k] = hs(pts[0][k], pts[1][k]);
      pb[k] = hs(pts[1][k], pts[2][k]);
      pm[k] = hs(pa[k], pb[k]);
    end
  end

  // output beat: whole chord, left half or right half
  always_comb begin
    out_valid = valid;
    out_pts   = pts;
    out_flags = flags;
    if (!flags.line) begin
      if (!phase) begin
        out_pts[1]     = pa;
        out_pts[2]     = pm;
        out_flags.last = 1'b0;
        out_flags.done = 1'b0;
      end else begin
        out_pts[0] = pm;
        out_pts[1] = pb;
      end
    end
  end

  assign final_beat = flags.line || phase;
  assign in_ready   = !valid || (out_ready && final_beat);

  // holding register and half select
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (valid && out_ready) begin
        if (final_beat) begin
          valid <= 1'b0;
          phase <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end
      if (in_valid && in_ready) begin
        valid <= 1'b1;
        phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pts   <= in_pts;
      flags <= in_flags;
    end
  end

  `CHQB_ASSERT(a_phase_curve, (phase |-> (valid && !flags.line)),
    "right half pending on an empty or straight stage")
  `CHQB_ASSERT(a_left_then_right,
    ((valid && out_ready && !final_beat) |=> (valid && phase)),
    "left half sent but right half lost")

endmodule

>>> rtl/chqb_back.sv
// ----------------------------------------------------------------------------
// chqb_back
// Chord engine: a chain of subdivision levels feeding a small result queue.
// ----------------------------------------------------------------------------
module chqb_back #(
  parameter int W = 16,
  parameter int D = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   seg_valid,
  output logic                   seg_ready,
  input  logic [2:0][1:0][W-1:0] seg_pts,
  input  chqb_pkg::seg_flags_t   seg_flags,
  output logic                   empty,
  input  logic                   pop,
  output logic [W-1:0]           start_x,
  output logic [W-1:0]           start_y,
  output logic [W-1:0]           end_x,
  output logic [W-1:0]           end_y,
  output logic                   last_chord,
  output logic                   curve_done
);
  import chqb_pkg::*;

  localparam int OW = 4 * W + 2;

  logic [D:0]             c_valid;
  logic [D:0]             c_ready;
  logic [2:0][1:0][W-1:0] c_pts   [D+1];
  seg_flags_t             c_flags [D+1];
  logic                   oq_full;
  logic [OW-1:0]          oq_din;
  logic [OW-1:0]          oq_dout;

  assign c_valid[0] = seg_valid;
  assign c_pts[0]   = seg_pts;
  assign c_flags[0] = seg_flags;
  assign seg_ready  = c_ready[0];

  // one stage per subdivision level
  for (genvar g = 0; g < D; g++) begin : g_lvl
    chqb_split #(.W(W)) u_split (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_pts    (c_pts[g]),
      .in_flags  (c_flags[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_pts   (c_pts[g+1]),
      .out_flags (c_flags[g+1])
    );
  end

  // leaf chords into the result queue
  assign c_ready[D] = !oq_full;
  assign oq_din = {c_pts[D][0][0], c_pts[D][0][1], c_pts[D][2][0], c_pts[D][2][1],
                   c_flags[D].last, c_flags[D].done};

  chqb_queue #(.WIDTH(OW), .DEPTH(2)) u_oq (
    .clk   (clk),
    .rst   (rst),
    .push  (c_valid[D] && c_ready[D]),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty)
  );

  assign start_x    = oq_dout[4*W+1:3*W+2];
  assign start_y    = oq_dout[3*W+1:2*W+2];
  assign end_x      = oq_dout[2*W+1:W+2];
  assign end_y      = oq_dout[W+1:2];
  assign last_chord = oq_dout[1];
  assign curve_done = oq_dout[0];

endmodule

>>> rtl/chorded_quadratic_bspline.sv
// ----------------------------------------------------------------------------
// chorded_quadratic_bspline
// Polyline points in, quadratic B-spline chords out, by midpoint subdivision.
//
//   channel  | handshake      | beat
//   ---------+----------------+------------------------------------------
//   point    | push / full    | pos_x, pos_y, final_point
//   chord    | pop / empty    | start_x, start_y, end_x, end_y,
//            |                | last_chord, curve_done
//
// An interior vertex yields 2**SUBDIVISION_DEPTH chords at one per cycle
// while the result queue has room; the last subdivision stage, which hands
// out one half per cycle, sets that rate. The first chord of a point passes
// the segment queue, every subdivision stage and the result queue, all
// registered, before it appears.
// Reset clears the polyline state and all queues.
// full rises only when the two-entry segment queue is full; pop may stall
// freely, the chain and queues hold their contents.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chorded_quadratic_bspline #(
  parameter int COORD_BITS        = 16,
  parameter int SUBDIVISION_DEPTH = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic                         final_point,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic signed [COORD_BITS-1:0] end_x,
  output logic signed [COORD_BITS-1:0] end_y,
  output logic                         last_chord,
  output logic                         curve_done
);
  import chqb_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int SW = 6 * W + FLAG_BITS;

  logic                   seg_push;
  logic                   seg_full;
  logic [2:0][1:0][W-1:0] f_pts;
  seg_flags_t             f_flags;
  logic                   sq_empty;
  logic [SW-1:0]          sq_dout;
  logic                   b_ready;
  logic [2:0][1:0][W-1:0] b_pts;
  seg_flags_t             b_flags;

  // intake and classification
  chqb_front #(.W(W)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .final_point (final_point),
    .full        (full),
    .seg_push    (seg_push),
    .seg_pts     (f_pts),
    .seg_flags   (f_flags),
    .seg_full    (seg_full)
  );

  // segment queue between front and chord engine
  chqb_queue #(.WIDTH(SW), .DEPTH(2)) u_sq (
    .clk   (clk),
    .rst   (rst),
    .push  (seg_push),
    .din   ({f_pts, f_flags}),
    .full  (seg_full),
    .pop   (b_ready),
    .dout  (sq_dout),
    .empty (sq_empty)
  );

  assign b_pts   = sq_dout[SW-1:FLAG_BITS];
  assign b_flags = sq_dout[FLAG_BITS-1:0];

  // subdivision and result buffering
  chqb_back #(.W(W), .D(SUBDIVISION_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .seg_valid  (!sq_empty),
    .seg_ready  (b_ready),
    .seg_pts    (b_pts),
    .seg_flags  (b_flags),
    .empty      (empty),
    .pop        (pop),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .last_chord (last_chord),
    .curve_done (curve_done)
  );

  `CHQB_ASSERT_ALWAYS(a_empty_after_rst, ($past(rst) |-> empty),
    "result queue not empty after reset")
  `CHQB_ASSERT(a_done_is_last, ((!empty && curve_done) |-> last_chord),
    "polyline end flagged on a chord that is not last for its point")
  `CHQB_ASSERT(a_seg_in_no_push, ((seg_push) |-> (push && !full)),
    "segment queued without an accepted point")

endmodule
